// File: rtl/core/overlay_stuck_watchdog_core_assert.svh
// Assertion macros for the overlay stuck watchdog core.
// Included by the controller and datapath; no other dependencies.
`ifndef OVERLAY_STUCK_WATCHDOG_CORE_ASSERT_SVH
`define OVERLAY_STUCK_WATCHDOG_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define OSW_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define OSW_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define OSW_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define OSW_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// File: rtl/core/osw_pkg.sv
// Shared types and constants for the overlay stuck watchdog core.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package osw_pkg;

	localparam int NUM_CHANNELS_DEF = 4;

	localparam int FUNC_W     = 2;
	localparam int IDX_W      = 2;
	localparam int TIME_W     = 44;
	localparam int DUR_W      = 31;
	localparam int KIND_W     = 3;
	localparam int S_TDATA_W  = 48;
	localparam int M_TDATA_W  = 40;

	localparam logic [DUR_W-1:0] THR_RESET = 31'd3000;
	localparam logic [DUR_W-1:0] THR_MIN   = 31'd1;
	localparam logic [DUR_W-1:0] DUR_MAX   = '1;

	typedef enum logic [FUNC_W-1:0] {
		FN_VIS  = 2'd0,
		FN_TICK = 2'd1,
		FN_REC  = 2'd2,
		FN_LOAD = 2'd3
	} func_t;

	typedef enum logic [KIND_W-1:0] {
		EV_STUCK = 3'd0,
		EV_ANY   = 3'd1,
		EV_HDONE = 3'd2,
		EV_REC   = 3'd3,
		EV_LOAD  = 3'd4
	} ev_kind_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_CALC,
		ST_EVAL,
		ST_SUMMARY,
		ST_HDONE,
		ST_REC_ANY,
		ST_REC_DONE,
		ST_LOAD_EMIT
	} state_t;

	typedef struct packed {
		logic     load;
		logic     vis_apply;
		logic     scan_start;
		logic     calc;
		logic     eval;
		logic     scan_next;
		logic     clear_all;
		logic     clear_one;
		logic     emit;
		ev_kind_t emit_kind;
		logic     emit_last;
	} cmd_t;

	typedef struct packed {
		func_t func;
		logic  out_free;
		logic  report;
		logic  scan_last;
		logic  any_change;
	} status_t;

endpackage

`default_nettype wire

// File: rtl/core/osw_datapath.sv
// Datapath: channel state, threshold, scan unit and output register.
// Depends on osw_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "overlay_stuck_watchdog_core_assert.svh"

module osw_datapath #(
	parameter int NUM_CHANNELS = osw_pkg::NUM_CHANNELS_DEF
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire [osw_pkg::S_TDATA_W-1:0] s_tdata,
	input  wire [osw_pkg::FUNC_W-1:0]    s_tuser,
	input  wire                          cfg_valid,
	input  wire [osw_pkg::DUR_W-1:0]     cfg_data,
	input  wire osw_pkg::cmd_t           cmd,
	output osw_pkg::status_t             status,
	output logic                         m_tvalid,
	input  wire                          m_tready,
	output logic [osw_pkg::M_TDATA_W-1:0] m_tdata,
	output logic [osw_pkg::KIND_W-1:0]   m_tuser,
	output logic                         m_tlast
);
	import osw_pkg::*;

	localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int PAD_W = M_TDATA_W - IDX_W - DUR_W - 1;

	logic [NUM_CHANNELS-1:0] chan_vis_q;
	logic [NUM_CHANNELS-1:0] chan_rep_q;
	logic [TIME_W-1:0]       chan_since_q [NUM_CHANNELS];
	logic                    any_stuck_q;
	logic [DUR_W-1:0]        thr_q;

	func_t             func_q;
	logic [IDX_W-1:0]  idx_q;
	logic              vis_q;
	logic [TIME_W-1:0] now_q;

	logic [CH_W-1:0]   scan_q;
	logic              stuck_q;
	logic [DUR_W-1:0]  dur_s1;
	logic              elig_s1;

	logic              out_valid_q;
	ev_kind_t          out_kind_q;
	logic [IDX_W-1:0]  out_chan_q;
	logic [DUR_W-1:0]  out_dur_q;
	logic              out_flag_q;
	logic              out_last_q;

	logic              idx_ok;
	logic [CH_W-1:0]   idx_ch;
	logic [TIME_W:0]   diff;
	logic [DUR_W-1:0]  dur_sat;
	logic              hit;
	logic              any_target;

	assign idx_ok = (32'(idx_q) < NUM_CHANNELS);
	assign idx_ch = CH_W'(idx_q);

	// borrow out of the wide subtract means now is before since
	assign diff = {1'b0, now_q} - {1'b0, chan_since_q[scan_q]};
	always_comb begin
		if (diff[TIME_W]) begin
			dur_sat = '0;
		end else if (diff[TIME_W-1:DUR_W] != '0) begin
			dur_sat = DUR_MAX;
		end else begin
			dur_sat = diff[DUR_W-1:0];
		end
	end

	assign hit        = elig_s1 && (dur_s1 >= thr_q);
	assign any_target = (func_q == FN_REC) ? 1'b0 : stuck_q;

	assign status.func       = func_q;
	assign status.out_free   = !out_valid_q || m_tready;
	assign status.report     = hit && !chan_rep_q[scan_q];
	assign status.scan_last  = (scan_q == CH_W'(NUM_CHANNELS - 1));
	assign status.any_change = (any_stuck_q != any_target);

	// threshold register, zero is stored as one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
		end else if (cfg_valid) begin
			thr_q <= (cfg_data == '0) ? THR_MIN : cfg_data;
		end
	end

	// request capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= func_t'(s_tuser);
			idx_q  <= s_tdata[IDX_W-1:0];
			vis_q  <= s_tdata[IDX_W];
			now_q  <= s_tdata[IDX_W+TIME_W:IDX_W+1];
		end
	end

	// channel state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_vis_q  <= '0;
			chan_rep_q  <= '0;
			any_stuck_q <= 1'b0;
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				chan_since_q[i] <= '0;
			end
		end else begin
			if (cmd.vis_apply && idx_ok && (chan_vis_q[idx_ch] != vis_q)) begin
				chan_vis_q[idx_ch]   <= vis_q;
				chan_since_q[idx_ch] <= vis_q ? now_q : '0;
				if (!vis_q) begin
					chan_rep_q[idx_ch] <= 1'b0;
				end
			end
			if (cmd.clear_one && idx_ok && chan_vis_q[idx_ch]) begin
				chan_vis_q[idx_ch]   <= 1'b0;
				chan_rep_q[idx_ch]   <= 1'b0;
				chan_since_q[idx_ch] <= '0;
			end
			if (cmd.clear_all) begin
				chan_vis_q <= '0;
				chan_rep_q <= '0;
				for (int i = 0; i < NUM_CHANNELS; i++) begin
					chan_since_q[i] <= '0;
				end
			end
			if (cmd.emit && (cmd.emit_kind == EV_STUCK)) begin
				chan_rep_q[scan_q] <= 1'b1;
			end
			if (cmd.emit && (cmd.emit_kind == EV_ANY)) begin
				any_stuck_q <= any_target;
			end
		end
	end

	// scan unit: one channel per calc/eval pair
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q  <= '0;
			stuck_q <= 1'b0;
		end else begin
			if (cmd.scan_start) begin
				scan_q  <= '0;
				stuck_q <= 1'b0;
			end else if (cmd.scan_next) begin
				scan_q <= scan_q + 1'b1;
			end
			if (cmd.eval && hit) begin
				stuck_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.calc) begin
			dur_s1  <= dur_sat;
			elig_s1 <= chan_vis_q[scan_q] && (chan_since_q[scan_q] != '0);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_kind_q <= cmd.emit_kind;
			out_last_q <= cmd.emit_last;
			out_chan_q <= '0;
			out_dur_q  <= '0;
			out_flag_q <= 1'b0;
			case (cmd.emit_kind)
				EV_STUCK: begin
					out_chan_q <= IDX_W'(scan_q);
					out_dur_q  <= dur_s1;
				end
				EV_ANY:   out_flag_q <= any_target;
				EV_HDONE: out_flag_q <= !stuck_q;
				EV_LOAD:  out_chan_q <= idx_q;
				default:  out_flag_q <= 1'b0;
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{PAD_W{1'b0}}, out_flag_q, out_dur_q, out_chan_q};
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_last_q;

	`OSW_ASSERT_IMP(a_emit_free, clk, arst_n, cmd.emit, !out_valid_q || m_tready, "emit overwrote a pending result")
	`OSW_ASSERT_IMP(a_rep_vis, clk, arst_n, 1'b1, (chan_rep_q & ~chan_vis_q) == '0, "reported flag on hidden channel")
	`OSW_ASSERT_IMP(a_stuck_dur, clk, arst_n, out_valid_q && (out_kind_q == EV_STUCK), out_dur_q >= thr_q, "stuck result below threshold")

endmodule

`default_nettype wire

// File: rtl/core/osw_ctrl.sv
// Controller state machine: sequences decode, channel scan and result emission.
// Depends on osw_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "overlay_stuck_watchdog_core_assert.svh"

module osw_ctrl (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                s_tvalid,
	output logic               s_tready,
	input  wire osw_pkg::status_t status,
	output osw_pkg::cmd_t      cmd
);
	import osw_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// a channel with a new report needs a free output slot before moving on
	assign advance = !status.report || status.out_free;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) state_d = ST_DECODE;
			end
			ST_DECODE: begin
				unique case (status.func)
					FN_VIS:  state_d = ST_IDLE;
					FN_TICK: state_d = ST_CALC;
					FN_REC:  state_d = ST_REC_ANY;
					FN_LOAD: state_d = ST_LOAD_EMIT;
					default: state_d = ST_IDLE;
				endcase
			end
			ST_CALC: state_d = ST_EVAL;
			ST_EVAL: begin
				if (advance) state_d = status.scan_last ? ST_SUMMARY : ST_CALC;
			end
			ST_SUMMARY: begin
				if (!status.any_change || status.out_free) state_d = ST_HDONE;
			end
			ST_HDONE: begin
				if (status.out_free) state_d = ST_IDLE;
			end
			ST_REC_ANY: begin
				if (!status.any_change || status.out_free) state_d = ST_REC_DONE;
			end
			ST_REC_DONE, ST_LOAD_EMIT: begin
				if (status.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.emit_kind = EV_STUCK;
		s_tready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				cmd.load = s_tvalid;
			end
			ST_DECODE: begin
				unique case (status.func)
					FN_VIS:  cmd.vis_apply  = 1'b1;
					FN_TICK: cmd.scan_start = 1'b1;
					FN_REC:  cmd.clear_all  = 1'b1;
					FN_LOAD: cmd.clear_one  = 1'b1;
					default: cmd.vis_apply  = 1'b0;
				endcase
			end
			ST_CALC: cmd.calc = 1'b1;
			ST_EVAL: begin
				cmd.eval = 1'b1;
				cmd.emit = status.report && status.out_free;
				cmd.emit_kind = EV_STUCK;
				cmd.scan_next = advance && !status.scan_last;
			end
			ST_SUMMARY, ST_REC_ANY: begin
				cmd.emit = status.any_change && status.out_free;
				cmd.emit_kind = EV_ANY;
			end
			ST_HDONE: begin
				cmd.emit = status.out_free;
				cmd.emit_kind = EV_HDONE;
				cmd.emit_last = 1'b1;
			end
			ST_REC_DONE: begin
				cmd.emit = status.out_free;
				cmd.emit_kind = EV_REC;
				cmd.emit_last = 1'b1;
			end
			ST_LOAD_EMIT: begin
				cmd.emit = status.out_free;
				cmd.emit_kind = EV_LOAD;
				cmd.emit_last = 1'b1;
			end
			default: s_tready = 1'b0;
		endcase
	end

	`OSW_ASSERT_NXT(a_accept_decode, clk, arst_n, s_tvalid && s_tready, state_q == ST_DECODE, "accepted request not decoded")
	`OSW_ASSERT_NXT(a_last_idle, clk, arst_n, cmd.emit && cmd.emit_last, state_q == ST_IDLE, "final result did not end the request")
	`OSW_ASSERT_NXT(a_eval_hold, clk, arst_n, (state_q == ST_EVAL) && status.report && !status.out_free, state_q == ST_EVAL, "pending stuck report dropped")

endmodule

`default_nettype wire

// File: rtl/core/overlay_stuck_watchdog_core.sv
// Overlay stuck watchdog: per-channel visibility timer with stuck detection.
// Request steps: accept in idle, then decode. Visibility applies its change in decode;
// load error emits its event; recovery emits any summary change, then its done event;
// health tick runs a calc/eval pair per channel, then the summary change and done event.
// One request at a time: the next is accepted only back in idle, so output stalls delay it.
// Reset (arst_n low, async): channel state and summary cleared, threshold 3000 ms.
`timescale 1ns / 1ps
`default_nettype none

module overlay_stuck_watchdog_core #(
	parameter int NUM_CHANNELS = osw_pkg::NUM_CHANNELS_DEF
) (
	input  wire                           clk,
	input  wire                           arst_n,
	// request stream
	input  wire                           s_tvalid,
	output logic                          s_tready,
	// [1:0] overlay_index, [2] visible_now, [46:3] now_ms, [47] zero
	input  wire [osw_pkg::S_TDATA_W-1:0]  s_tdata,
	// [1:0] func
	input  wire [osw_pkg::FUNC_W-1:0]     s_tuser,
	// result stream
	output logic                          m_tvalid,
	input  wire                           m_tready,
	// [1:0] event_channel, [32:2] stuck_duration_ms, [33] event_flag, [39:34] zero
	output logic [osw_pkg::M_TDATA_W-1:0] m_tdata,
	// [2:0] event_kind
	output logic [osw_pkg::KIND_W-1:0]    m_tuser,
	// last_event
	output logic                          m_tlast,
	// threshold write, taken at any time
	input  wire                           cfg_valid,
	output logic                          cfg_ready,
	input  wire [osw_pkg::DUR_W-1:0]      cfg_data
);
	import osw_pkg::*;

	cmd_t    cmd;
	status_t status;

	// the threshold register has no back pressure
	assign cfg_ready = 1'b1;

	// controller: decodes a request and steps the datapath through it
	osw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	// datapath: channel timers, duration subtract/saturate, result register
	osw_datapath #(
		.NUM_CHANNELS (NUM_CHANNELS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.status    (status),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule

`default_nettype wire

// File: test/overlay_stuck_watchdog_checker.sv
// Checker for the overlay stuck watchdog: watches request, result and threshold channels,
// predicts the event stream per request and compares it field by field.
// Depends on osw_pkg for widths and the func/event enums.
`timescale 1ns / 1ps

module overlay_stuck_watchdog_checker (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            s_tvalid,
	input  wire                            s_tready,
	// [1:0] overlay_index, [2] visible_now, [46:3] now_ms, [47] zero
	input  wire [osw_pkg::S_TDATA_W-1:0]   s_tdata,
	// [1:0] func
	input  wire [osw_pkg::FUNC_W-1:0]      s_tuser,
	input  wire                            m_tvalid,
	input  wire                            m_tready,
	// [1:0] event_channel, [32:2] stuck_duration_ms, [33] event_flag, [39:34] zero
	input  wire [osw_pkg::M_TDATA_W-1:0]   m_tdata,
	// [2:0] event_kind
	input  wire [osw_pkg::KIND_W-1:0]      m_tuser,
	input  wire                            m_tlast,
	input  wire                            cfg_valid,
	input  wire                            cfg_ready,
	input  wire [osw_pkg::DUR_W-1:0]       cfg_data,
	output int                             fail_count,
	output int                             pending_count,
	output int                             request_count,
	output int                             event_count,
	output int                             stuck_count
);
	import osw_pkg::*;

	localparam int CHANNELS = NUM_CHANNELS_DEF;

	typedef struct {
		ev_kind_t         kind;
		logic [IDX_W-1:0] chan;
		logic [DUR_W-1:0] dur;
		logic             flag;
		logic             last;
	} watch_event_t;

	// shadow of the channel table and threshold
	logic             chan_on[CHANNELS];
	logic [TIME_W-1:0] chan_since[CHANNELS];
	logic             chan_flagged[CHANNELS];
	logic             any_stuck;
	logic [DUR_W-1:0] threshold;

	watch_event_t expected_events[$];
	int fails = 0;
	int requests = 0;
	int events = 0;
	int stucks = 0;

	function automatic void post_event(ev_kind_t kind, logic [IDX_W-1:0] chan,
			logic [DUR_W-1:0] dur, logic flag);
		watch_event_t ev;
		ev.kind = kind;
		ev.chan = chan;
		ev.dur  = dur;
		ev.flag = flag;
		ev.last = 1'b0;
		expected_events.push_back(ev);
	endfunction

	function automatic void update_summary(logic stuck);
		if (any_stuck != stuck) begin
			any_stuck = stuck;
			post_event(EV_ANY, '0, '0, stuck);
		end
	endfunction

	function automatic void clear_channel(int i);
		chan_on[i]      = 1'b0;
		chan_since[i]   = '0;
		chan_flagged[i] = 1'b0;
	endfunction

	function automatic void predict_request(func_t fn, logic [IDX_W-1:0] idx, logic vis,
			logic [TIME_W-1:0] now);
		logic              stuck;
		logic [TIME_W-1:0] span;
		logic [DUR_W-1:0]  dur;
		stuck = 1'b0;
		case (fn)
			FN_VIS: begin
				if (int'(idx) < CHANNELS && chan_on[idx] != vis) begin
					chan_on[idx]    = vis;
					chan_since[idx] = vis ? now : '0;
					if (!vis)
						chan_flagged[idx] = 1'b0;
				end
				return;
			end
			FN_TICK: begin
				for (int i = 0; i < CHANNELS; i++) begin
					if (!chan_on[i] || chan_since[i] == '0)
						continue;
					span = (now >= chan_since[i]) ? now - chan_since[i] : '0;
					dur  = (span > TIME_W'(DUR_MAX)) ? DUR_MAX : span[DUR_W-1:0];
					if (dur >= threshold) begin
						stuck = 1'b1;
						if (!chan_flagged[i]) begin
							chan_flagged[i] = 1'b1;
							post_event(EV_STUCK, IDX_W'(i), dur, 1'b0);
						end
					end
				end
				update_summary(stuck);
				post_event(EV_HDONE, '0, '0, !stuck);
			end
			FN_REC: begin
				for (int i = 0; i < CHANNELS; i++)
					clear_channel(i);
				update_summary(1'b0);
				post_event(EV_REC, '0, '0, 1'b0);
			end
			default: begin
				if (int'(idx) < CHANNELS && chan_on[idx])
					clear_channel(int'(idx));
				post_event(EV_LOAD, idx, '0, 1'b0);
			end
		endcase
		expected_events[expected_events.size()-1].last = 1'b1;
	endfunction

	function automatic void compare(string field, longint unsigned want, longint unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", field, want, got);
			fails++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		watch_event_t want;
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++)
				clear_channel(i);
			any_stuck = 1'b0;
			threshold = THR_RESET;
			expected_events.delete();
		end else begin
			// results first: a request accepted now cannot answer in the same cycle
			if (m_tvalid && m_tready) begin
				events++;
				if (expected_events.size() == 0) begin
					$error("event_kind: expected none, got %0d", m_tuser);
					fails++;
				end else begin
					want = expected_events.pop_front();
					compare("event_kind", want.kind, m_tuser);
					compare("event_channel", want.chan, m_tdata[1:0]);
					compare("stuck_duration_ms", want.dur, m_tdata[32:2]);
					compare("event_flag", want.flag, m_tdata[33]);
					compare("last_event", want.last, m_tlast);
					if (want.kind == EV_STUCK)
						stucks++;
				end
			end
			if (s_tvalid && s_tready) begin
				requests++;
				predict_request(func_t'(s_tuser), s_tdata[1:0], s_tdata[2], s_tdata[46:3]);
			end
			if (cfg_valid && cfg_ready)
				threshold = (cfg_data == '0) ? THR_MIN : cfg_data;
		end
		fail_count    <= fails;
		pending_count <= expected_events.size();
		request_count <= requests;
		event_count   <= events;
		stuck_count   <= stucks;
	end

endmodule

// File: test/overlay_stuck_watchdog_core_tb.sv
// Top of the overlay stuck watchdog testbench: clock, reset, request and threshold stimulus,
// result back-pressure and the final verdict.
// Depends on osw_pkg, overlay_stuck_watchdog_core and overlay_stuck_watchdog_checker.
`timescale 1ns / 1ps

module overlay_stuck_watchdog_core_tb;
	import osw_pkg::*;

	localparam int SETTLE_CYCLES = 24;   // longer than a health tick request, with margin
	localparam int HOLD_CYCLES   = 250;  // long result stall to back up the request side

	typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_TOGGLE} rx_mode_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                 s_tvalid = 1'b0;
	wire                  s_tready;
	logic [S_TDATA_W-1:0] s_tdata = '0;
	logic [FUNC_W-1:0]    s_tuser = FN_VIS;
	wire                  m_tvalid;
	logic                 m_tready = 1'b0;
	wire [M_TDATA_W-1:0]  m_tdata;
	wire [KIND_W-1:0]     m_tuser;
	wire                  m_tlast;
	logic                 cfg_valid = 1'b0;
	wire                  cfg_ready;
	logic [DUR_W-1:0]     cfg_data = '0;

	int fail_count, pending_count, request_count, event_count, stuck_count;

	// sender pacing and receiver stall control
	int   burst_left = 0;
	logic squeeze_req = 1'b0;
	logic squeeze_done = 1'b0;
	int   hold_left = 0;
	int   mode_left = 0;
	rx_mode_t rx_mode = RX_OPEN;

	// running millisecond clock for the random part, and the current threshold
	logic [TIME_W-1:0] clock_ms = '0;
	logic [DUR_W-1:0]  thr_now = THR_RESET;
	int settings = 1;

	always #5 clk = ~clk;

	overlay_stuck_watchdog_core #(
		.NUM_CHANNELS(NUM_CHANNELS_DEF)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	overlay_stuck_watchdog_checker u_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.s_tuser      (s_tuser),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.m_tuser      (m_tuser),
		.m_tlast      (m_tlast),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.fail_count   (fail_count),
		.pending_count(pending_count),
		.request_count(request_count),
		.event_count  (event_count),
		.stuck_count  (stuck_count)
	);

	// Receiver: switches between stall patterns, each held for a random stretch. Once the
	// stimulus asks for it, it holds off completely for HOLD_CYCLES so the result
	// side backs up and the block has to stall its request input.
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			m_tready <= 1'b0;
		end else if (squeeze_req && !squeeze_done) begin
			squeeze_done = 1'b1;
			hold_left = HOLD_CYCLES;
			m_tready <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				rx_mode = rx_mode_t'($urandom_range(0, 3));
				mode_left = $urandom_range(16, 80);
			end
			mode_left = mode_left - 1;
			case (rx_mode)
				RX_OPEN:   m_tready <= 1'b1;
				RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
				RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
				default:   m_tready <= ~m_tready;
			endcase
		end
	end

	// Offer one request and return at the edge that accepts it. Requests come in
	// bursts; a burst that ran out first opens a gap with valid low. Valid stays
	// high between back-to-back requests, it is never dropped and raised in one step.
	task automatic send_request(func_t fn, logic [IDX_W-1:0] idx, logic vis,
			logic [TIME_W-1:0] now);
		if (burst_left <= 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = ($urandom_range(0, 9) < 2) ? $urandom_range(20, 60)
				: $urandom_range(1, 6);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= fn;
		s_tdata  <= {1'b0, now, vis, idx};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		burst_left--;
	endtask

	// Stop offering, wait for every predicted event, then let the block settle
	// (visibility changes produce nothing, so an empty queue alone is not idle).
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_count != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		burst_left = 0;
	endtask

	task automatic write_threshold(logic [DUR_W-1:0] value);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		thr_now = (value == '0) ? THR_MIN : value;
		settings++;
	endtask

	// Random requests around the running clock. Most steps move time by up to the
	// threshold, capped at 20000, so channels drift into the stuck range over a few ticks;
	// some jump past the threshold or far enough to saturate the duration, a few
	// land on an arbitrary 44-bit stamp, on zero, or just before the clock.
	task automatic run_random(int count);
		int unsigned       span;
		int unsigned       pick;
		logic [63:0]       wide;
		logic [TIME_W-1:0] stamp;
		func_t             fn;
		span = (thr_now > 20000) ? 20000 : int'(thr_now);
		for (int k = 0; k < count; k++) begin
			pick = $urandom_range(0, 99);
			wide = {$urandom, $urandom};
			if (pick < 65)
				clock_ms += TIME_W'($urandom_range(0, span));
			else if (pick < 75)
				clock_ms += TIME_W'(thr_now) + TIME_W'($urandom_range(0, span));
			else if (pick < 80)
				clock_ms += TIME_W'(wide[33:0]);
			else if (pick < 84)
				clock_ms = wide[TIME_W-1:0];
			stamp = clock_ms;
			if (pick >= 84 && pick < 87)
				stamp = '0;
			else if (pick >= 87 && pick < 91)
				stamp = clock_ms - TIME_W'($urandom_range(1, span + 1));

			pick = $urandom_range(0, 99);
			if (pick < 45)
				fn = FN_VIS;
			else if (pick < 84)
				fn = FN_TICK;
			else if (pick < 95)
				fn = FN_LOAD;
			else
				fn = FN_REC;
			send_request(fn, IDX_W'($urandom_range(0, 3)), ($urandom_range(0, 9) < 7), stamp);
		end
	endtask

	initial begin
		#5_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, threshold at its reset value of 3000 ms.
		send_request(FN_TICK, 2'd0, 1'b0, 44'd0);              // nothing visible: healthy
		send_request(FN_VIS, 2'd0, 1'b1, 44'd0);               // visible at time zero: skipped
		send_request(FN_VIS, 2'd1, 1'b1, 44'd1000);
		send_request(FN_VIS, 2'd1, 1'b1, 44'd5000);            // unchanged: keeps the old stamp
		send_request(FN_VIS, 2'd2, 1'b1, '1);                  // stamp at the top of the range
		send_request(FN_VIS, 2'd3, 1'b1, 44'd2000);
		send_request(FN_TICK, 2'd3, 1'b0, 44'd3999);           // one below, and ch2 before start
		send_request(FN_TICK, 2'd0, 1'b1, 44'd4000);           // ch1 exactly at threshold
		send_request(FN_TICK, 2'd2, 1'b0, 44'd5000);           // ch1 already reported, ch3 new
		send_request(FN_VIS, 2'd1, 1'b0, 44'd5000);            // hide clears the report
		send_request(FN_LOAD, 2'd3, 1'b1, 44'd5100);
		send_request(FN_LOAD, 2'd0, 1'b0, 44'd5200);
		send_request(FN_LOAD, 2'd1, 1'b0, 44'd5300);           // not visible: event only
		send_request(FN_VIS, 2'd3, 1'b0, 44'd5400);            // already hidden
		send_request(FN_TICK, 2'd1, 1'b1, 44'd6000);           // summary drops back
		send_request(FN_VIS, 2'd0, 1'b1, 44'd1);
		send_request(FN_TICK, 2'd2, 1'b1, 44'h0_8000_0001);    // duration saturates
		send_request(FN_TICK, 2'd3, 1'b0, '1);
		send_request(FN_REC, 2'd2, 1'b1, 44'h0_8000_0002);     // summary cleared, then done
		send_request(FN_REC, 2'd1, 1'b0, 44'h0_8000_0003);     // nothing stuck any more
		clock_ms = 44'd10000;

		// Random part under several thresholds. The first stretch runs back to
		// back while the receiver holds off, so the request side must stall.
		burst_left = 1000;
		squeeze_req <= 1'b1;
		run_random(40);
		burst_left = 0;
		run_random(40);

		write_threshold(31'd1);
		run_random(70);
		write_threshold(31'd0);                                 // stored as 1
		run_random(40);
		write_threshold(DUR_MAX);
		run_random(70);
		write_threshold(DUR_W'($urandom_range(2, 200)));
		run_random(70);
		write_threshold(DUR_W'($urandom_range(1000, 100000)));
		run_random(70);

		wait_idle();
		$display("Covered %0d requests and %0d checked events (%0d stuck reports)",
			request_count, event_count, stuck_count);
		$display("across %0d threshold settings, including one long result stall.", settings);
		if (fail_count == 0 && pending_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
